// ===== rtl/jetp_pkg.sv =====
// Package with shared constants, register indexes and a saturation helper for the Julia pixel engine.
`timescale 1ns / 1ps

package jetp_pkg;

    // Fixed point format of all coordinates.
    localparam int FRAC_BITS   = 26;
    localparam int COORD_W     = 32;
    localparam int PROD_W      = 2 * COORD_W;
    localparam int WIDE_W      = PROD_W + 1;
    localparam int PIXEL_W     = 10;
    localparam int COUNT_W     = 16;
    localparam int BAILOUT_W   = 31;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_STEP_RE   = 3'd0,
        REG_STEP_IM   = 3'd1,
        REG_OFFSET_RE = 3'd2,
        REG_OFFSET_IM = 3'd3,
        REG_CONST_RE  = 3'd4,
        REG_CONST_IM  = 3'd5,
        REG_MAX_ITER  = 3'd6,
        REG_BAILOUT   = 3'd7
    } cfg_reg_t;

    // Register values after reset.
    localparam logic signed [COORD_W-1:0] RST_STEP_RE   = 32'sd262144;
    localparam logic signed [COORD_W-1:0] RST_STEP_IM   = 32'sd262144;
    localparam logic signed [COORD_W-1:0] RST_OFFSET_RE = -32'sd134217728;
    localparam logic signed [COORD_W-1:0] RST_OFFSET_IM = -32'sd134217728;
    localparam logic signed [COORD_W-1:0] RST_CONST_RE  = -32'sd53687091;
    localparam logic signed [COORD_W-1:0] RST_CONST_IM  = 32'sd10737418;
    localparam logic [COUNT_W-1:0]        RST_MAX_ITER  = 16'd256;
    localparam logic [BAILOUT_W-1:0]      RST_BAILOUT   = 31'd268435456;

    // Saturation bounds at the wide intermediate width.
    localparam logic signed [WIDE_W-1:0] SAT_MAX = 65'sd2147483647;
    localparam logic signed [WIDE_W-1:0] SAT_MIN = -65'sd2147483648;

    // Clamp a wide signed value to the signed coordinate range.
    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [WIDE_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > SAT_MAX) begin
            r = {1'b0, {(COORD_W-1){1'b1}}};
        end else if (v < SAT_MIN) begin
            r = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/jetp_mul.sv =====
// Shared signed 32 by 32 multiplier with a registered product.
`timescale 1ns / 1ps

module jetp_mul (
    input  logic                                 clk,
    input  logic signed [jetp_pkg::COORD_W-1:0] a,
    input  logic signed [jetp_pkg::COORD_W-1:0] b,
    output logic signed [jetp_pkg::PROD_W-1:0]  product
);
    import jetp_pkg::*;

    logic signed [PROD_W-1:0] product_reg;

    // One multiplication per cycle, result available the cycle after.
    always_ff @(posedge clk)
    begin
        product_reg <= a * b;
    end

    assign product = product_reg;

endmodule

// ===== rtl/julia_escape_time_pixel.sv =====
// Top level of the Julia set escape-time pixel engine.
//
//  Channel  | Ports                                        | Handshake
//  ---------+----------------------------------------------+-------------------------
//  command  | start, pixel_x, pixel_y                      | taken when start && !busy
//  result   | done, iteration_count, escaped, final_re/im  | done high for one cycle
//  config   | cfg_we, cfg_addr, cfg_data                   | written when cfg_we high
//
// A pixel runs from the accepting edge through ST_MUL_X, ST_MUL_Y and ST_LOAD_IM, which form
// the start point, and then through ST_SQ_RE, ST_SQ_IM, ST_CHECK and ST_UPDATE for every
// iteration, because re*re, im*im and re*im share one pipelined multiplier. ST_CHECK tests
// the magnitude and the limit and either raises done or goes on to ST_UPDATE.
// busy is high from the accepting edge until the done strobe; a new transaction
// may be accepted in the cycle in which done is shown. The receiver cannot stall.
// Reset restores the default view and Julia constant and returns to idle.
`timescale 1ns / 1ps

module julia_escape_time_pixel (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [jetp_pkg::PIXEL_W-1:0]           pixel_x,
    input  logic [jetp_pkg::PIXEL_W-1:0]           pixel_y,
    output logic                                   done,
    output logic [jetp_pkg::COUNT_W-1:0]           iteration_count,
    output logic                                   escaped,
    output logic signed [jetp_pkg::COORD_W-1:0]    final_re,
    output logic signed [jetp_pkg::COORD_W-1:0]    final_im,
    input  logic                                   cfg_we,
    input  logic [jetp_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [jetp_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import jetp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_X,
        ST_MUL_Y,
        ST_LOAD_IM,
        ST_SQ_RE,
        ST_SQ_IM,
        ST_CHECK,
        ST_UPDATE
    } state_t;

    // Configuration registers.
    logic signed [COORD_W-1:0] step_re_reg, step_im_reg;
    logic signed [COORD_W-1:0] offset_re_reg, offset_im_reg;
    logic signed [COORD_W-1:0] const_re_reg, const_im_reg;
    logic [COUNT_W-1:0]        max_iter_reg;
    logic [BAILOUT_W-1:0]      bailout_reg;

    // Sequencer and datapath registers.
    state_t                    state_reg, state_next;
    logic [PIXEL_W-1:0]        px_reg, px_next, py_reg, py_next;
    logic signed [COORD_W-1:0] re_reg, re_next, im_reg, im_next;
    logic signed [COORD_W-1:0] nre_reg, nre_next;
    logic signed [PROD_W-1:0]  rr_reg, rr_next;
    logic [COUNT_W-1:0]        count_reg, count_next;
    logic                      done_reg, done_next;
    logic                      escaped_reg, escaped_next;

    // Shared multiplier operands and product.
    logic signed [COORD_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0]  product;

    // Escape test and next real part.
    logic [PROD_W-1:0]         mag;
    logic                      below;
    logic signed [PROD_W-1:0]  diff;
    logic signed [WIDE_W-1:0]  nre_wide, nim_wide, start_wide;
    logic signed [COORD_W-1:0] start_off;

    jetp_mul u_mul (
        .clk     (clk),
        .a       (mul_a),
        .b       (mul_b),
        .product (product)
    );

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_re_reg   <= RST_STEP_RE;
            step_im_reg   <= RST_STEP_IM;
            offset_re_reg <= RST_OFFSET_RE;
            offset_im_reg <= RST_OFFSET_IM;
            const_re_reg  <= RST_CONST_RE;
            const_im_reg  <= RST_CONST_IM;
            max_iter_reg  <= RST_MAX_ITER;
            bailout_reg   <= RST_BAILOUT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_STEP_RE:   step_re_reg   <= cfg_data;
                REG_STEP_IM:   step_im_reg   <= cfg_data;
                REG_OFFSET_RE: offset_re_reg <= cfg_data;
                REG_OFFSET_IM: offset_im_reg <= cfg_data;
                REG_CONST_RE:  const_re_reg  <= cfg_data;
                REG_CONST_IM:  const_im_reg  <= cfg_data;
                REG_MAX_ITER:  max_iter_reg  <= cfg_data[COUNT_W-1:0];
                REG_BAILOUT:   bailout_reg   <= cfg_data[BAILOUT_W-1:0];
                default:       ;
            endcase
        end
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = re_reg;
        mul_b = re_reg;
        case (state_reg)
            ST_MUL_X:
            begin
                mul_a = signed'({{(COORD_W-PIXEL_W){1'b0}}, px_reg});
                mul_b = step_re_reg;
            end
            ST_MUL_Y:
            begin
                mul_a = signed'({{(COORD_W-PIXEL_W){1'b0}}, py_reg});
                mul_b = step_im_reg;
            end
            ST_SQ_IM:
            begin
                mul_a = im_reg;
                mul_b = im_reg;
            end
            ST_CHECK:
            begin
                mul_a = re_reg;
                mul_b = im_reg;
            end
            default:
            begin
                mul_a = re_reg;
                mul_b = re_reg;
            end
        endcase
    end

    // Squared magnitude against bailout, using re^2 held and im^2 on the product.
    assign mag   = unsigned'(rr_reg) + unsigned'(product);
    assign below = (mag >> FRAC_BITS) < {{(PROD_W-BAILOUT_W){1'b0}}, bailout_reg};

    // Next real part: floor((re^2 - im^2) / 2^FRAC_BITS) + const_re.
    assign diff     = rr_reg - product;
    assign nre_wide = WIDE_W'(diff >>> FRAC_BITS) + WIDE_W'(const_re_reg);

    // Next imaginary part: floor(2*re*im / 2^FRAC_BITS) + const_im.
    assign nim_wide = WIDE_W'(product >>> (FRAC_BITS - 1)) + WIDE_W'(const_im_reg);

    // Start point: pixel times step plus origin offset.
    assign start_off  = (state_reg == ST_MUL_Y) ? offset_re_reg : offset_im_reg;
    assign start_wide = WIDE_W'(product) + WIDE_W'(start_off);

    // Sequencer next-state logic.
    always_comb
    begin
        state_next   = state_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        re_next      = re_reg;
        im_next      = im_reg;
        nre_next     = nre_reg;
        rr_next      = rr_reg;
        count_next   = count_reg;
        done_next    = 1'b0;
        escaped_next = escaped_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    px_next    = pixel_x;
                    py_next    = pixel_y;
                    count_next = '0;
                    state_next = ST_MUL_X;
                end
            end
            ST_MUL_X:
            begin
                state_next = ST_MUL_Y;
            end
            ST_MUL_Y:
            begin
                re_next    = sat_coord(start_wide);
                state_next = ST_LOAD_IM;
            end
            ST_LOAD_IM:
            begin
                im_next    = sat_coord(start_wide);
                state_next = ST_SQ_RE;
            end
            ST_SQ_RE:
            begin
                state_next = ST_SQ_IM;
            end
            ST_SQ_IM:
            begin
                rr_next    = product;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                // Stop at the limit or once the point has left the bailout disk.
                if ((count_reg >= max_iter_reg) || !below)
                begin
                    done_next    = 1'b1;
                    escaped_next = !below;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    nre_next   = sat_coord(nre_wide);
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                re_next    = nre_reg;
                im_next    = sat_coord(nim_wide);
                count_next = count_reg + 1'b1;
                state_next = ST_SQ_RE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge clk)
    begin
        px_reg      <= px_next;
        py_reg      <= py_next;
        re_reg      <= re_next;
        im_reg      <= im_next;
        nre_reg     <= nre_next;
        rr_reg      <= rr_next;
        count_reg   <= count_next;
        escaped_reg <= escaped_next;
    end

    assign busy            = (state_reg != ST_IDLE);
    assign done            = done_reg;
    assign iteration_count = count_reg;
    assign escaped         = escaped_reg;
    assign final_re        = re_reg;
    assign final_im        = im_reg;

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the Julia set escape-time pixel engine.
`timescale 1ns / 1ps

module testbench;

    import jetp_pkg::*;

    localparam int      RANDOM_ITEMS = 1050;
    localparam int      TAIL_CYCLES  = 64;
    localparam longint  TIMEOUT_NS   = 64'd100_000_000;

    // One pixel result, tagged with the coordinates that caused it.
    typedef struct packed {
        logic [PIXEL_W-1:0] px;
        logic [PIXEL_W-1:0] py;
        logic [COUNT_W-1:0] count;
        logic               esc;
        logic [COORD_W-1:0] fre;
        logic [COORD_W-1:0] fim;
    } pixel_result_t;

    // Rows of the directed stimulus table.
    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_PIXEL,
        ROW_PIXEL_KNOWN
    } row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        cfg_reg_t          addr;
        logic [CFG_DATA_W-1:0] wdata;
        pixel_result_t     known;
    } plan_row_t;

    // Kinds of register settings used by the random phases.
    typedef enum logic [2:0] {
        VIEW_TYPICAL,
        VIEW_DEEP,
        VIEW_WILD,
        VIEW_EXTREME,
        VIEW_RESET
    } view_kind_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [PIXEL_W-1:0]   pixel_x;
    logic [PIXEL_W-1:0]   pixel_y;
    logic                 done;
    logic [COUNT_W-1:0]   iteration_count;
    logic                 escaped;
    logic signed [COORD_W-1:0] final_re;
    logic signed [COORD_W-1:0] final_im;
    logic                 cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Local copy of the register file, kept at the register widths.
    logic [CFG_DATA_W-1:0] cfg_mirror [8];

    pixel_result_t pending_pixels [$];
    plan_row_t     plan [$];

    int mismatches       = 0;
    int results_checked  = 0;
    int escaped_seen     = 0;
    int capped_seen      = 0;
    int deepest_count    = 0;
    int views_programmed = 0;
    int burst_left       = 0;
    bit steady           = 1'b0;

    julia_escape_time_pixel dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .pixel_x         (pixel_x),
        .pixel_y         (pixel_y),
        .done            (done),
        .iteration_count (iteration_count),
        .escaped         (escaped),
        .final_re        (final_re),
        .final_im        (final_im),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_data        (cfg_data)
    );

    always #6 clk = ~clk;

    // Register value as a signed 64-bit number.
    function automatic longint signed_reg(input cfg_reg_t a);
        return longint'(signed'(cfg_mirror[a]));
    endfunction

    // Clamp to the signed 32-bit coordinate range.
    function automatic logic [COORD_W-1:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[COORD_W-1:0];
    endfunction

    // Exact test floor(|z|^2 / 2^FRAC_BITS) < bailout.
    function automatic bit under_bailout(input logic signed [COORD_W-1:0] re, im);
        longint unsigned a;
        longint unsigned b;
        a = (re < 0) ? -longint'(re) : longint'(re);
        b = (im < 0) ? -longint'(im) : longint'(im);
        return ((a * a + b * b) >> FRAC_BITS) < {32'd0, cfg_mirror[REG_BAILOUT]};
    endfunction

    // Escape-time iteration of one pixel under the current registers.
    function automatic pixel_result_t julia_escape(input logic [PIXEL_W-1:0] px,
                                                   input logic [PIXEL_W-1:0] py);
        pixel_result_t res;
        logic signed [COORD_W-1:0] re;
        logic signed [COORD_W-1:0] im;
        longint rr;
        longint ii;
        longint ri;
        int unsigned n;
        re = clamp32(longint'(px) * signed_reg(REG_STEP_RE) + signed_reg(REG_OFFSET_RE));
        im = clamp32(longint'(py) * signed_reg(REG_STEP_IM) + signed_reg(REG_OFFSET_IM));
        n = 0;
        while (n < cfg_mirror[REG_MAX_ITER] && under_bailout(re, im))
        begin
            rr = longint'(re) * longint'(re);
            ii = longint'(im) * longint'(im);
            ri = longint'(re) * longint'(im);
            re = clamp32(((rr - ii) >>> FRAC_BITS) + signed_reg(REG_CONST_RE));
            im = clamp32((ri >>> (FRAC_BITS - 1)) + signed_reg(REG_CONST_IM));
            n++;
        end
        res.px    = px;
        res.py    = py;
        res.count = 16'(n);
        res.esc   = !under_bailout(re, im);
        res.fre   = re;
        res.fim   = im;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // Register write; called at a falling edge while the engine is idle.
    task automatic write_reg(input cfg_reg_t addr, input logic [CFG_DATA_W-1:0] data);
        cfg_we   = 1'b1;
        cfg_addr = addr;
        cfg_data = data;
        case (addr)
            REG_MAX_ITER: cfg_mirror[addr] = {16'd0, data[COUNT_W-1:0]};
            REG_BAILOUT:  cfg_mirror[addr] = {1'b0, data[BAILOUT_W-1:0]};
            default:      cfg_mirror[addr] = data;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Wait until every expected result is in and the engine is free.
    task automatic wait_idle();
        while (pending_pixels.size() != 0 || busy !== 1'b0)
            @(negedge clk);
    endtask

    // Sender pacing: bursts of random length separated by random gaps, or no gaps when steady is set.
    task automatic pace_sender();
        int gap;
        if (steady)
            return;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 50) : $urandom_range(0, 6);
            repeat (gap) @(negedge clk);
        end
        burst_left--;
    endtask

    // One command transaction; the expectation is queued on acceptance.
    task automatic send_pixel(input pixel_result_t want);
        start   = 1'b1;
        pixel_x = want.px;
        pixel_y = want.py;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        pending_pixels.push_back(want);
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic plan_write(input cfg_reg_t addr, input logic [CFG_DATA_W-1:0] data);
        plan_row_t row;
        row       = '0;
        row.kind  = ROW_WRITE;
        row.addr  = addr;
        row.wdata = data;
        plan.push_back(row);
    endtask

    task automatic plan_pixel(input logic [PIXEL_W-1:0] x, y);
        plan_row_t row;
        row          = '0;
        row.kind     = ROW_PIXEL;
        row.known.px = x;
        row.known.py = y;
        plan.push_back(row);
    endtask

    task automatic plan_known(input logic [PIXEL_W-1:0] x, y, input logic [COUNT_W-1:0] cnt,
                              input logic esc, input logic [COORD_W-1:0] re, im);
        plan_row_t row;
        row             = '0;
        row.kind        = ROW_PIXEL_KNOWN;
        row.known.px    = x;
        row.known.py    = y;
        row.known.count = cnt;
        row.known.esc   = esc;
        row.known.fre   = re;
        row.known.fim   = im;
        plan.push_back(row);
    endtask

    function automatic logic [CFG_DATA_W-1:0] extreme_word();
        case ($urandom_range(0, 3))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0;
            default: return $urandom();
        endcase
    endfunction

    // Program all eight registers with a setting of the given kind.
    task automatic program_view(input view_kind_t kind);
        int span;
        int step_r;
        int step_i;
        logic [CFG_DATA_W-1:0] vals [8];
        case (kind)
            VIEW_TYPICAL, VIEW_DEEP:
            begin
                // The image spans 0.5 to 4.0 around a center near the origin.
                span   = $urandom_range(1 << 25, 1 << 28);
                step_r = span >>> 10;
                step_i = ($urandom_range(0, 3) == 0) ? -(span >>> 10) : (span >>> 10);
                vals[REG_STEP_RE]   = step_r;
                vals[REG_STEP_IM]   = step_i;
                vals[REG_OFFSET_RE] = int'($urandom_range(0, 1 << 27)) - (1 << 26) - 512 * step_r;
                vals[REG_OFFSET_IM] = int'($urandom_range(0, 1 << 27)) - (1 << 26) - 512 * step_i;
                vals[REG_CONST_RE]  = int'($urandom_range(0, 1 << 27)) - (1 << 26);
                vals[REG_CONST_IM]  = int'($urandom_range(0, 1 << 27)) - (1 << 26);
                vals[REG_BAILOUT]   = ($urandom_range(0, 3) != 0) ? 32'd268435456
                                    : $urandom_range(32'h0100_0000, 32'h7FFF_FFFF);
                if (kind == VIEW_DEEP)
                    vals[REG_MAX_ITER] = $urandom_range(100, 256);
                else if ($urandom_range(0, 7) == 0)
                    vals[REG_MAX_ITER] = $urandom_range(25, 64);
                else
                    vals[REG_MAX_ITER] = $urandom_range(1, 24);
            end
            VIEW_WILD:
            begin
                for (int i = 0; i < 8; i++)
                    vals[i] = $urandom();
                // Keep the limit small while still toggling the upper data bits.
                vals[REG_MAX_ITER][COUNT_W-1:0] = 16'($urandom_range(0, 20));
            end
            VIEW_EXTREME:
            begin
                for (int i = 0; i < 6; i++)
                    vals[i] = extreme_word();
                case ($urandom_range(0, 2))
                    0:       vals[REG_MAX_ITER] = 32'd0;
                    1:       vals[REG_MAX_ITER] = 32'd1;
                    default: vals[REG_MAX_ITER] = 32'd65535;
                endcase
                // The longest limit only runs with a zero threshold, so it stays short.
                if (vals[REG_MAX_ITER] == 32'd65535)
                    vals[REG_BAILOUT] = 32'd0;
                else
                    vals[REG_BAILOUT] = extreme_word();
            end
            default:
            begin
                vals[REG_STEP_RE]   = RST_STEP_RE;
                vals[REG_STEP_IM]   = RST_STEP_IM;
                vals[REG_OFFSET_RE] = RST_OFFSET_RE;
                vals[REG_OFFSET_IM] = RST_OFFSET_IM;
                vals[REG_CONST_RE]  = RST_CONST_RE;
                vals[REG_CONST_IM]  = RST_CONST_IM;
                vals[REG_MAX_ITER]  = {16'd0, RST_MAX_ITER};
                vals[REG_BAILOUT]   = {1'b0, RST_BAILOUT};
            end
        endcase
        for (int i = 0; i < 8; i++)
            write_reg(cfg_reg_t'(i), vals[i]);
        views_programmed++;
    endtask

    // Result checker: each done strobe is matched against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        pixel_result_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_pixels.size() == 0)
            begin
                report_mismatch("result transaction with no pixel pending");
            end
            else
            begin
                want = pending_pixels.pop_front();
                results_checked++;
                if (iteration_count !== want.count)
                    report_mismatch($sformatf("pixel (%0d,%0d) count %0d, want %0d",
                                              want.px, want.py, iteration_count, want.count));
                if (escaped !== want.esc)
                    report_mismatch($sformatf("pixel (%0d,%0d) escaped %b, want %b",
                                              want.px, want.py, escaped, want.esc));
                if (final_re !== want.fre)
                    report_mismatch($sformatf("pixel (%0d,%0d) final_re %h, want %h",
                                              want.px, want.py, final_re, want.fre));
                if (final_im !== want.fim)
                    report_mismatch($sformatf("pixel (%0d,%0d) final_im %h, want %h",
                                              want.px, want.py, final_im, want.fim));
                if (want.esc)
                    escaped_seen++;
                else
                    capped_seen++;
                if (int'(want.count) > deepest_count)
                    deepest_count = int'(want.count);
            end
        end
    end

    // Stimulus: directed table first, then random phases of register settings.
    initial
    begin : stimulus
        int items_sent;
        int phase_items;
        int pick;
        view_kind_t kind;

        rst_n    = 1'b0;
        start    = 1'b0;
        pixel_x  = '0;
        pixel_y  = '0;
        cfg_we   = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        cfg_mirror[REG_STEP_RE]   = RST_STEP_RE;
        cfg_mirror[REG_STEP_IM]   = RST_STEP_IM;
        cfg_mirror[REG_OFFSET_RE] = RST_OFFSET_RE;
        cfg_mirror[REG_OFFSET_IM] = RST_OFFSET_IM;
        cfg_mirror[REG_CONST_RE]  = RST_CONST_RE;
        cfg_mirror[REG_CONST_IM]  = RST_CONST_IM;
        cfg_mirror[REG_MAX_ITER]  = {16'd0, RST_MAX_ITER};
        cfg_mirror[REG_BAILOUT]   = {1'b0, RST_BAILOUT};
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Corners and center of the default view.
        plan_pixel(10'd0, 10'd0);
        plan_pixel(10'd1023, 10'd1023);
        plan_pixel(10'd512, 10'd512);
        plan_pixel(10'd1023, 10'd0);
        plan_pixel(10'd0, 10'd1023);
        // A zero threshold makes every start point count as escaped.
        plan_write(REG_BAILOUT, 32'd0);
        plan_known(10'd0, 10'd0, 16'd0, 1'b1, -32'sd134217728, -32'sd134217728);
        plan_known(10'd1023, 10'd1023, 16'd0, 1'b1, 32'sd133955584, 32'sd133955584);
        // Zero iteration limit: the start point is returned as is.
        plan_write(REG_MAX_ITER, 32'd0);
        plan_write(REG_BAILOUT, 32'd268435456);
        plan_known(10'd512, 10'd512, 16'd0, 1'b0, 32'sd0, 32'sd0);
        plan_known(10'd0, 10'd0, 16'd0, 1'b1, -32'sd134217728, -32'sd134217728);
        // A single iteration from the origin lands on c; the next one escapes on the last step.
        plan_write(REG_MAX_ITER, 32'd1);
        plan_known(10'd512, 10'd512, 16'd1, 1'b0, -32'sd53687091, 32'sd10737418);
        plan_pixel(10'd998, 10'd512);
        // Start point saturates high on the real axis and low on the imaginary axis.
        plan_write(REG_STEP_RE, 32'h7FFF_FFFF);
        plan_write(REG_OFFSET_RE, 32'h7FFF_FFFF);
        plan_write(REG_STEP_IM, 32'h8000_0000);
        plan_write(REG_OFFSET_IM, 32'h8000_0000);
        plan_write(REG_MAX_ITER, 32'd0);
        plan_known(10'd1023, 10'd1023, 16'd0, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000);
        plan_known(10'd0, 10'd0, 16'd0, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000);
        // Iteration results saturate when c sits at the extremes.
        plan_write(REG_STEP_RE, 32'd0);
        plan_write(REG_OFFSET_RE, 32'd0);
        plan_write(REG_STEP_IM, 32'd0);
        plan_write(REG_OFFSET_IM, 32'd0);
        plan_write(REG_CONST_RE, 32'h7FFF_FFFF);
        plan_write(REG_CONST_IM, 32'h8000_0000);
        plan_write(REG_MAX_ITER, 32'd3);
        plan_write(REG_BAILOUT, 32'h7FFF_FFFF);
        plan_pixel(10'd5, 10'd5);
        plan_write(REG_CONST_RE, 32'h8000_0000);
        plan_pixel(10'd1023, 10'd0);
        // Largest limit with a zero threshold, then a far start point at the largest threshold.
        plan_write(REG_MAX_ITER, 32'd65535);
        plan_write(REG_BAILOUT, 32'd0);
        plan_known(10'd7, 10'd9, 16'd0, 1'b1, 32'sd0, 32'sd0);
        plan_write(REG_BAILOUT, 32'h7FFF_FFFF);
        plan_write(REG_OFFSET_RE, 32'h7FFF_FFFF);
        plan_known(10'd0, 10'd0, 16'd0, 1'b1, 32'h7FFF_FFFF, 32'sd0);

        foreach (plan[i])
        begin
            case (plan[i].kind)
                ROW_WRITE:
                begin
                    wait_idle();
                    write_reg(plan[i].addr, plan[i].wdata);
                end
                ROW_PIXEL:
                begin
                    pace_sender();
                    send_pixel(julia_escape(plan[i].known.px, plan[i].known.py));
                end
                default:
                begin
                    pace_sender();
                    send_pixel(plan[i].known);
                end
            endcase
        end

        // Random phases: mostly well-formed views, some wild and extreme settings.
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 15);
            if (pick < 10)
                kind = VIEW_TYPICAL;
            else if (pick < 12)
                kind = VIEW_WILD;
            else if (pick < 14)
                kind = VIEW_EXTREME;
            else if (pick == 14)
                kind = VIEW_RESET;
            else
                kind = VIEW_DEEP;
            if (kind == VIEW_RESET || kind == VIEW_DEEP)
                phase_items = $urandom_range(3, 8);
            else
                phase_items = $urandom_range(10, 40);
            steady     = ($urandom_range(0, 4) == 0);
            burst_left = 0;
            wait_idle();
            program_view(kind);
            repeat (phase_items)
            begin
                pace_sender();
                send_pixel(julia_escape(10'($urandom_range(0, 1023)),
                                        10'($urandom_range(0, 1023))));
                items_sent++;
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(negedge clk);
        $display("Checked %0d pixel results under %0d random register settings plus the table.",
                 results_checked, views_programmed);
        $display("%0d escaped, %0d stopped at the limit, deepest iteration count %0d.",
                 escaped_seen, capped_seen, deepest_count);
        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    // Watchdog against a hung engine.
    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("Timeout: results still pending after %0d ns.", TIMEOUT_NS);
        $display("testbench NOT OK");
        $finish;
    end

endmodule
